[design/edt_pkg.sv]
`timescale 1ns / 1ps

package edt_pkg;

	// Operation codes of an input word.
	typedef enum logic [2:0] {
		OP_FIND_ID   = 3'd0,
		OP_FIND_IEEE = 3'd1,
		OP_SET_CD    = 3'd2,
		OP_TICK      = 3'd3,
		OP_READ      = 3'd4,
		OP_INSERT    = 3'd5,
		OP_DELETE    = 3'd6
	} op_t;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// Commands broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_ROTATE = 3'd1,
		CELL_TICK   = 3'd2,
		CELL_SET    = 3'd3,
		CELL_INSERT = 3'd4,
		CELL_DELETE = 3'd5
	} cell_op_t;

	typedef struct packed {
		logic [7:0]        machine_id;
		logic [15:0]       short_addr;
		logic [63:0]       ieee_addr;
		logic signed [7:0] countdown;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   data;
	} cell_ctl_t;

endpackage

[design/end_device_table_core.sv]
`timescale 1ns / 1ps

// Ordered table of up to CAPACITY end devices held in a ring of cells, one entry per
// cell. For set, tick, insert, delete and unused opcodes the cells update in parallel
// at the edge that takes the input word; the result is then loaded into the output
// register from the emit state once that register is free. Find by id, find by IEEE
// address and read first walk the ring: it rotates by one cell per cycle until it has
// gone once round, so that every entry passes the head cell, where it is compared or
// captured, and the ring ends up in its original order. A new input word is taken only
// once the previous result sits in the output register. No clearing pass follows reset.
module end_device_table_core #(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              opcode,
	input  logic [$clog2(CAPACITY+1)-1:0] position,
	input  logic [7:0]              machine_id,
	input  logic [15:0]             short_addr,
	input  logic [63:0]             ieee_addr,
	input  logic signed [7:0]       countdown,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [$clog2(CAPACITY+1)-1:0] found_position,
	output logic [7:0]              out_machine_id,
	output logic [15:0]             out_short_addr,
	output logic [63:0]             out_ieee_addr,
	output logic signed [7:0]       out_countdown,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count
);
	import edt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	op_t             op_q;
	logic [IW-1:0]   k_q;
	logic [7:0]      mid_q;
	logic [63:0]     ieee_q;
	logic [IW-1:0]   j_q;
	logic            found_q;

	logic [1:0]        res_status_q;
	logic [CW-1:0]     res_fpos_q;
	logic [7:0]        res_mid_q;
	logic [15:0]       res_sa_q;
	logic [63:0]       res_ieee_q;
	logic signed [7:0] res_cd_q;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [CW-1:0]     out_fpos_q;
	logic [7:0]        out_mid_q;
	logic [15:0]       out_sa_q;
	logic [63:0]       out_ieee_q;
	logic signed [7:0] out_cd_q;
	logic [CW-1:0]     out_count_q;

	entry_t    cells [CAPACITY];
	entry_t    head;
	cell_ctl_t cell_ctl;
	logic [IW-1:0] cell_k;

	op_t           op_in;
	logic          in_acc;
	logic          pos_nz;
	logic [CW-1:0] k_set;
	logic          set_ok;
	logic          rd_ok;
	logic          ins_ok;
	logic          full;
	logic          j_in_use;
	logic          hit;
	logic          out_load;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign op_in    = op_t'(opcode);
	assign head     = cells[0];

	// Position checks, all against the count before this operation.
	assign pos_nz = (position != '0);
	assign k_set  = pos_nz ? (position - CW'(1)) : '0;
	assign set_ok = (k_set < count_q);
	assign rd_ok  = pos_nz && (position <= count_q);
	assign ins_ok = pos_nz && ((CW+1)'(position) <= ((CW+1)'(count_q) + (CW+1)'(1)));
	assign full   = (count_q == FULL_CNT);
	assign cell_k = k_set[IW-1:0];

	assign j_in_use = (CW'(j_q) < count_q);
	assign hit = (op_q == OP_FIND_ID) ? (head.machine_id == mid_q) : (head.ieee_addr == ieee_q);

	always_comb begin
		cell_ctl.op   = CELL_HOLD;
		cell_ctl.data = '{machine_id: machine_id, short_addr: short_addr,
				ieee_addr: ieee_addr, countdown: countdown};
		if (state_q == S_WALK) begin
			cell_ctl.op = CELL_ROTATE;
		end else if (in_acc) begin
			case (op_in)
				OP_SET_CD: begin
					if (set_ok) begin
						cell_ctl.op = CELL_SET;
					end
				end
				OP_TICK: begin
					cell_ctl.op = CELL_TICK;
				end
				OP_INSERT: begin
					if (ins_ok && !full) begin
						cell_ctl.op = CELL_INSERT;
					end
				end
				OP_DELETE: begin
					if (rd_ok) begin
						cell_ctl.op = CELL_DELETE;
					end
				end
				default: begin
					cell_ctl.op = CELL_HOLD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		edt_cell #(
			.IW (IW),
			.CW (CW),
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.k         (cell_k),
			.count     (count_q),
			.prev_entry(cells[(i + CAPACITY - 1) % CAPACITY]),
			.next_entry(cells[(i + 1) % CAPACITY]),
			.entry     (cells[i])
		);
	end

	assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EMIT;
						case (op_in)
							OP_FIND_ID, OP_FIND_IEEE, OP_READ: begin
								state_q <= S_WALK;
								found_q <= 1'b0;
							end
							OP_INSERT: begin
								if (ins_ok && !full) begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_DELETE: begin
								if (rd_ok) begin
									count_q <= count_q - CW'(1);
								end
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_WALK: begin
					if ((op_q inside {OP_FIND_ID, OP_FIND_IEEE}) && !found_q
							&& j_in_use && hit) begin
						found_q <= 1'b1;
					end
					if (j_q == LAST_IDX) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operation context and result words.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= op_in;
			k_q    <= cell_k;
			mid_q  <= machine_id;
			ieee_q <= ieee_addr;
			j_q    <= '0;

			res_fpos_q <= '0;
			res_mid_q  <= '0;
			res_sa_q   <= '0;
			res_ieee_q <= '0;
			res_cd_q   <= '0;
			case (op_in)
				OP_SET_CD: res_status_q <= set_ok ? STAT_OK : STAT_MISS;
				OP_TICK:   res_status_q <= STAT_OK;
				OP_READ:   res_status_q <= rd_ok ? STAT_OK : STAT_MISS;
				OP_INSERT: res_status_q <= !ins_ok ? STAT_MISS : (full ? STAT_FULL : STAT_OK);
				OP_DELETE: res_status_q <= rd_ok ? STAT_OK : STAT_MISS;
				default:   res_status_q <= STAT_MISS;
			endcase
		end else if (state_q == S_WALK) begin
			j_q <= j_q + IW'(1);
			// The head cell holds entry j_q during this cycle of the walk.
			if ((op_q inside {OP_FIND_ID, OP_FIND_IEEE}) && !found_q
					&& j_in_use && hit) begin
				res_status_q <= STAT_OK;
				res_fpos_q   <= CW'(j_q) + CW'(1);
				res_sa_q     <= head.short_addr;
			end
			if (op_q == OP_READ && res_status_q == STAT_OK && j_q == k_q) begin
				res_mid_q  <= head.machine_id;
				res_sa_q   <= head.short_addr;
				res_ieee_q <= head.ieee_addr;
				res_cd_q   <= head.countdown;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_fpos_q   <= res_fpos_q;
			out_mid_q    <= res_mid_q;
			out_sa_q     <= res_sa_q;
			out_ieee_q   <= res_ieee_q;
			out_cd_q     <= res_cd_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign found_position = out_fpos_q;
	assign out_machine_id = out_mid_q;
	assign out_short_addr = out_sa_q;
	assign out_ieee_addr  = out_ieee_q;
	assign out_countdown  = out_cd_q;
	assign entry_count    = out_count_q;

endmodule

[design/edt_cell.sv]
`timescale 1ns / 1ps

module edt_cell #(
	parameter int IW  = 4,
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  edt_pkg::cell_ctl_t ctl,
	input  logic [IW-1:0]     k,
	input  logic [CW-1:0]     count,
	input  edt_pkg::entry_t   prev_entry,
	input  edt_pkg::entry_t   next_entry,
	output edt_pkg::entry_t   entry
);
	import edt_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);
	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_HOLD: begin
				entry_q <= entry_q;
			end
			CELL_ROTATE: begin
				entry_q <= next_entry;
			end
			CELL_TICK: begin
				// Only occupied cells count down; negative values clamp to zero.
				if (MY_POS < count) begin
					if (entry_q.countdown[7] || entry_q.countdown == 8'sd0) begin
						entry_q.countdown <= 8'sd0;
					end else begin
						entry_q.countdown <= entry_q.countdown - 8'sd1;
					end
				end
			end
			CELL_SET: begin
				if (k == MY_IDX) begin
					entry_q.countdown <= ctl.data.countdown;
				end
			end
			CELL_INSERT: begin
				if (k == MY_IDX) begin
					entry_q <= ctl.data;
				end else if (k < MY_IDX) begin
					entry_q <= prev_entry;
				end
			end
			CELL_DELETE: begin
				if (k <= MY_IDX) begin
					entry_q <= next_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;

endmodule
